// File: hdl/indexed_sequence_store_core_assert.svh
// Assertion macros shared by the indexed sequence store design.
`ifndef INDEXED_SEQUENCE_STORE_CORE_ASSERT_SVH
`define INDEXED_SEQUENCE_STORE_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define ISS_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked outside reset
`define ISS_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: hdl/iss_pkg.sv
// Package with sizes, codes and control types of the indexed sequence store.
`timescale 1ns / 1ps
package iss_pkg;

   localparam int CAPACITY = 16;
   localparam int CMD_W    = 3;
   localparam int POS_W    = 8;
   localparam int VAL_W    = 32;
   localparam int ST_W     = 2;
   localparam int CNTO_W   = 5;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int CMP_W    = (CNT_W > POS_W) ? CNT_W : POS_W;
   localparam int REQ_W    = ((CMD_W + POS_W + VAL_W + 7) / 8) * 8;
   localparam int RSP_W    = ((VAL_W + ST_W + CNTO_W + 7) / 8) * 8;

   typedef logic [CMP_W-1:0] cmp_type;
   typedef logic [CNT_W-1:0] cnt_type;
   typedef logic [VAL_W-1:0] val_type;

   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND  = 3'd0,
      CMD_PREPEND = 3'd1,
      CMD_INSERT  = 3'd2,
      CMD_READ    = 3'd3,
      CMD_DEL_HD  = 3'd4,
      CMD_DEL_TL  = 3'd5,
      CMD_DEL_AT  = 3'd6
   } cmd_code_type;

   typedef enum logic [ST_W-1:0] {
      STS_OK      = 2'd0,
      STS_INVALID = 2'd1,
      STS_EMPTY   = 2'd2,
      STS_FULL    = 2'd3
   } status_type;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // Commands from the controller to the datapath
   typedef struct packed {
      logic load;   // capture the incoming transaction
      logic exec;   // run the captured command and fill the result register
   } dp_cmd_type;

endpackage

// File: hdl/iss_ctrl.sv
// Controller state machine: request capture, command issue and result valid.
`timescale 1ns / 1ps
module iss_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output iss_pkg::dp_cmd_type dp_cmd
);
   import iss_pkg::*;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      slot_free;

   // result register can take a new result when empty or drained this cycle
   assign slot_free = !rsp_valid_ff || rsp_tready;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) state_in = ST_EXEC;
         end
         ST_EXEC: begin
            if (slot_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs; no request transaction is taken while reset is held
   always_comb begin
      req_tready  = 1'b0;
      dp_cmd.load = 1'b0;
      dp_cmd.exec = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready  = !reset;
            dp_cmd.load = req_tvalid && !reset;
         end
         ST_EXEC: begin
            dp_cmd.exec = slot_free;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (dp_cmd.exec) rsp_valid_in = 1'b1;
      else if (rsp_tready) rsp_valid_in = 1'b0;
   end

   assign rsp_tvalid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// File: hdl/iss_datapath.sv
// Datapath: shifting cell chain, entry count and result register.
`timescale 1ns / 1ps
module iss_datapath (
   input  logic                         clock,
   input  logic                         reset,
   input  iss_pkg::dp_cmd_type          dp_cmd,
   input  logic [iss_pkg::CMD_W-1:0]    in_command,
   input  logic [iss_pkg::POS_W-1:0]    in_position,
   input  logic [iss_pkg::VAL_W-1:0]    in_value,
   output logic [iss_pkg::VAL_W-1:0]    out_read_value,
   output logic [iss_pkg::ST_W-1:0]     out_status,
   output logic [iss_pkg::CNTO_W-1:0]   out_count
);
   import iss_pkg::*;

   // captured transaction
   cmd_code_type       cmd_ff;
   logic [POS_W-1:0]   pos_ff;
   val_type            val_ff;

   // list state
   val_type            cells_ff [CAPACITY];
   val_type            cells_in [CAPACITY];
   cnt_type            count_ff, count_in;

   // result register
   val_type            rd_ff, rd_in;
   status_type         st_ff, st_in;
   logic [CNTO_W-1:0]  cnto_ff;

   // decoded operation
   logic               ins_en, del_en;
   cmp_type            ins_pos, del_pos, pos_c, cnt_c;
   logic               is_full, is_empty;

   assign pos_c    = cmp_type'(pos_ff);
   assign cnt_c    = cmp_type'(count_ff);
   assign is_full  = (count_ff == cnt_type'(CAPACITY));
   assign is_empty = (count_ff == '0);

   // command decode and status
   always_comb begin
      ins_en   = 1'b0;
      del_en   = 1'b0;
      ins_pos  = '0;
      del_pos  = '0;
      rd_in    = '0;
      st_in    = STS_OK;
      count_in = count_ff;
      case (cmd_ff)
         CMD_APPEND: begin
            if (is_full) st_in = STS_FULL;
            else begin
               ins_en  = 1'b1;
               ins_pos = cnt_c;
            end
         end
         CMD_PREPEND: begin
            if (is_full) st_in = STS_FULL;
            else ins_en = 1'b1;
         end
         CMD_INSERT: begin
            if (pos_c > cnt_c) st_in = STS_INVALID;
            else if (is_full) st_in = STS_FULL;
            else begin
               ins_en  = 1'b1;
               ins_pos = pos_c;
            end
         end
         CMD_READ: begin
            if (pos_c >= cnt_c) begin
               st_in = STS_INVALID;
               rd_in = '1;
            end else begin
               rd_in = cells_ff[IDX_W'(pos_ff)];
            end
         end
         CMD_DEL_HD: begin
            if (is_empty) st_in = STS_EMPTY;
            else del_en = 1'b1;
         end
         CMD_DEL_TL: begin
            if (is_empty) st_in = STS_EMPTY;
            else count_in = count_ff - cnt_type'(1);
         end
         CMD_DEL_AT: begin
            if (pos_c >= cnt_c) st_in = STS_INVALID;
            else begin
               del_en  = 1'b1;
               del_pos = pos_c;
            end
         end
         default: begin
            st_in = STS_OK;
         end
      endcase
      if (ins_en) count_in = count_ff + cnt_type'(1);
      if (del_en) count_in = count_ff - cnt_type'(1);
   end

   // each cell takes its own value, the new value, its lower neighbor or its upper neighbor
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      val_type lower, upper;
      cmp_type here;
      assign here = cmp_type'(g);
      if (g == 0) begin : g_lo
         assign lower = cells_ff[g];
      end else begin : g_lo
         assign lower = cells_ff[g-1];
      end
      if (g == CAPACITY - 1) begin : g_hi
         assign upper = cells_ff[g];
      end else begin : g_hi
         assign upper = cells_ff[g+1];
      end
      always_comb begin
         cells_in[g] = cells_ff[g];
         if (ins_en) begin
            if (here > ins_pos) cells_in[g] = lower;
            else if (here == ins_pos) cells_in[g] = val_ff;
         end else if (del_en) begin
            if (here >= del_pos) cells_in[g] = upper;
         end
      end
   end

   // transaction capture, cell chain and result register (payload, no reset)
   always_ff @(posedge clock) begin
      if (dp_cmd.load) begin
         cmd_ff <= cmd_code_type'(in_command);
         pos_ff <= in_position;
         val_ff <= in_value;
      end
      if (dp_cmd.exec) begin
         cells_ff <= cells_in;
         rd_ff    <= rd_in;
         st_ff    <= st_in;
         cnto_ff  <= CNTO_W'(count_in);
      end
   end

   // entry count
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (dp_cmd.exec) begin
         count_ff <= count_in;
      end
   end

   assign out_read_value = rd_ff;
   assign out_status     = st_ff;
   assign out_count      = cnto_ff;

endmodule

// File: hdl/indexed_sequence_store_core.sv
// Top level of the indexed sequence store: stream ports, controller and datapath.
`timescale 1ns / 1ps
// Ordered list of up to 16 signed 32-bit entries held in a chain of cells that
// shift together. Each request transaction carries one command (append,
// prepend, insert at index, read at index, delete head, delete tail, delete at
// index) and returns exactly one response transaction with the read value, a
// status (ok, invalid index, empty, full) and the entry count after the command.
// A command is first captured from the request, then executed: the cell chain
// is updated and the response register loaded. No new request is taken until
// the captured command has executed. A new request is taken while the previous
// response still waits; execution then holds until that response is taken.
// Entries hold no reset value; only entries below the count are ever read.
module indexed_sequence_store_core (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   // [2:0] command, [10:3] position, [42:11] value, [47:43] zero
   input  logic [iss_pkg::REQ_W-1:0]   req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   // [31:0] read_value, [33:32] status, [38:34] count, [39] zero
   output logic [iss_pkg::RSP_W-1:0]   rsp_tdata
);
   import iss_pkg::*;

   `include "indexed_sequence_store_core_assert.svh"

   dp_cmd_type         dp_cmd;
   logic [VAL_W-1:0]   rd_value;
   logic [ST_W-1:0]    rd_status;
   logic [CNTO_W-1:0]  rd_count;

   iss_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .dp_cmd     (dp_cmd)
   );

   iss_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .dp_cmd         (dp_cmd),
      .in_command     (req_tdata[CMD_W-1:0]),
      .in_position    (req_tdata[CMD_W+POS_W-1:CMD_W]),
      .in_value       (req_tdata[CMD_W+POS_W+VAL_W-1:CMD_W+POS_W]),
      .out_read_value (rd_value),
      .out_status     (rd_status),
      .out_count      (rd_count)
   );

   // response packing, pad bits zero
   assign rsp_tdata = RSP_W'({rd_count, rd_status, rd_value});

   // a captured request blocks intake until it has executed
   `ISS_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_tvalid && req_tready, !req_tready, "request accepted while a command was pending")
   // full status only at capacity
   `ISS_ASSERT_SAME(a_full_count, clock, reset, rsp_tvalid && (rd_status == STS_FULL), rd_count == CNTO_W'(CAPACITY), "full status with count below capacity")
   // empty status only with no entries
   `ISS_ASSERT_SAME(a_empty_count, clock, reset, rsp_tvalid && (rd_status == STS_EMPTY), rd_count == '0, "empty status with entries present")
   // a stalled response is not overwritten
   `ISS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "pending response changed")

endmodule

// File: sim/tb_indexed_sequence_store_core.sv
// Testbench for indexed_sequence_store_core: directed table, then random command streams.
`timescale 1ns / 1ps
// Drives list commands over the request stream, predicts each response with a
// behavioral copy of the list and compares every response transaction field by
// field. Covers empty, full and bad-index cases, the one-entry tail delete, the
// unused command code and four handshake patterns including a long back-pressure
// stretch and a full drain between phases.
module tb_indexed_sequence_store_core;
   import iss_pkg::*;

   localparam logic [CMD_W-1:0] CMD_SPARE = 3'd7;   // unused code, must be ignored
   localparam int MODE_GROW   = 0;
   localparam int MODE_MIXED  = 1;
   localparam int MODE_SHRINK = 2;
   localparam int EPISODE_LEN = 40;

   typedef struct packed {
      logic [CMD_W-1:0] cmd;
      logic [POS_W-1:0] pos;
      val_type          value;
   } list_req_type;

   typedef struct packed {
      val_type           read_value;
      status_type        status;
      logic [CNTO_W-1:0] count;
   } list_rsp_type;

   typedef struct {
      list_req_type req;
      bit           fixed;    // response typed in below rather than predicted
      list_rsp_type rsp;
   } dir_row_type;

   logic               clock;
   logic               reset      = 1'b1;
   logic               req_tvalid = 1'b0;
   logic               req_tready;
   logic [REQ_W-1:0]   req_tdata  = '0;
   logic               rsp_tvalid;
   logic               rsp_tready = 1'b0;
   logic [RSP_W-1:0]   rsp_tdata;

   // Behavioral copy of the list
   val_type       list_entries [CAPACITY];
   int            list_len;
   list_rsp_type  pending_rsp_q [$];
   dir_row_type   dir_rows [$];

   int send_idle_pct;
   int recv_stall_pct;
   int hold_request;
   int err_count;
   int cmds_sent;
   int status_seen [4];

   indexed_sequence_store_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("FAIL indexed_sequence_store_core");
      $finish;
   end

   // Apply one command to the list copy and return the response it should give
   function automatic list_rsp_type apply_list_cmd(list_req_type c);
      list_rsp_type r;
      int           ins_at;
      int           del_at;
      int           i;
      r.read_value = '0;
      r.status     = STS_OK;
      ins_at       = -1;
      del_at       = -1;
      case (c.cmd)
         CMD_APPEND:  ins_at = list_len;
         CMD_PREPEND: ins_at = 0;
         CMD_INSERT: begin
            // index check wins over the full check
            if (int'(c.pos) > list_len) r.status = STS_INVALID;
            else ins_at = int'(c.pos);
         end
         CMD_READ: begin
            if (int'(c.pos) >= list_len) begin
               r.status     = STS_INVALID;
               r.read_value = '1;
            end else begin
               r.read_value = list_entries[c.pos];
            end
         end
         CMD_DEL_HD: begin
            if (list_len == 0) r.status = STS_EMPTY;
            else del_at = 0;
         end
         CMD_DEL_TL: begin
            if (list_len == 0) r.status = STS_EMPTY;
            else del_at = list_len - 1;
         end
         CMD_DEL_AT: begin
            if (int'(c.pos) >= list_len) r.status = STS_INVALID;
            else del_at = int'(c.pos);
         end
         default: ;
      endcase
      if (ins_at >= 0) begin
         if (list_len >= CAPACITY) begin
            r.status = STS_FULL;
         end else begin
            for (i = list_len; i > ins_at; i--) list_entries[i] = list_entries[i-1];
            list_entries[ins_at] = c.value;
            list_len++;
         end
      end
      if (del_at >= 0) begin
         for (i = del_at; i < list_len - 1; i++) list_entries[i] = list_entries[i+1];
         list_len--;
      end
      r.count = CNTO_W'(list_len);
      return r;
   endfunction

   function automatic dir_row_type dir_row(logic [CMD_W-1:0] cmd, int pos, val_type value,
                                           bit fixed, val_type rd, status_type st, int cnt);
      dir_row_type d;
      d.req.cmd        = cmd;
      d.req.pos        = POS_W'(pos);
      d.req.value      = value;
      d.fixed          = fixed;
      d.rsp.read_value = rd;
      d.rsp.status     = st;
      d.rsp.count      = CNTO_W'(cnt);
      return d;
   endfunction

   // Random command, weighted by mode; positions mostly near the live range
   function automatic list_req_type make_list_cmd(int mode);
      list_req_type c;
      int           w [7];
      int           r;
      int           k;
      int           pick;
      case (mode)
         MODE_GROW:   w = '{25, 45, 70, 85, 89, 93, 98};
         MODE_SHRINK: w = '{8, 14, 22, 40, 58, 74, 98};
         default:     w = '{14, 28, 42, 56, 70, 84, 98};
      endcase
      r    = $urandom_range(99);
      pick = 7;
      for (k = 6; k >= 0; k--) if (r < w[k]) pick = k;
      c.cmd = CMD_W'(pick);
      r = $urandom_range(99);
      if (r < 80)      c.pos = POS_W'($urandom_range(list_len, 0));
      else if (r < 90) c.pos = POS_W'($urandom_range(255, list_len));
      else             c.pos = POS_W'($urandom_range(255, 0));
      if ($urandom_range(9) == 0) begin
         case ($urandom_range(3))
            0:       c.value = 32'h8000_0000;
            1:       c.value = 32'h7FFF_FFFF;
            2:       c.value = 32'hFFFF_FFFF;
            default: c.value = 32'h0000_0000;
         endcase
      end else begin
         c.value = $urandom;
      end
      return c;
   endfunction

   // Offer one request transaction; predict its response once accepted
   task automatic send_list_cmd(list_req_type c, bit fixed, list_rsp_type fixed_rsp);
      list_rsp_type predicted;
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_W - CMD_W - POS_W - VAL_W){1'b0}}, c.value, c.pos, c.cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = apply_list_cmd(c);
      pending_rsp_q.push_back(fixed ? fixed_rsp : predicted);
      cmds_sent++;
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // Response side: random stalls plus an occasional long hold-off
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   // Response checker
   always @(posedge clock) begin
      list_rsp_type got;
      list_rsp_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.read_value = rsp_tdata[31:0];
         got.status     = status_type'(rsp_tdata[33:32]);
         got.count      = rsp_tdata[38:34];
         status_seen[got.status]++;
         if (pending_rsp_q.size() == 0) begin
            $display("%0t: response transaction with nothing expected: %h", $time, rsp_tdata);
            err_count++;
         end else begin
            want = pending_rsp_q.pop_front();
            if (got.read_value !== want.read_value) begin
               $display("%0t: read_value expected %h actual %h",
                        $time, want.read_value, got.read_value);
               err_count++;
            end
            if (got.status !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
               err_count++;
            end
            if (got.count !== want.count) begin
               $display("%0t: count expected %0d actual %0d", $time, want.count, got.count);
               err_count++;
            end
         end
      end
   end

   // Stimulus
   initial begin
      int  p;
      int  e;
      int  n;
      list_req_type c;
      list_rsp_type no_rsp;
      err_count      = 0;
      cmds_sent      = 0;
      hold_request   = 0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      list_len       = 0;
      status_seen    = '{0, 0, 0, 0};
      no_rsp         = '0;

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty list, bad indexes, unused code, extremes, one-entry tail delete
      dir_rows.push_back(dir_row(CMD_DEL_HD,  0,   32'h0,        1, 32'h0, STS_EMPTY,   0));
      dir_rows.push_back(dir_row(CMD_DEL_TL,  0,   32'h0,        1, 32'h0, STS_EMPTY,   0));
      dir_rows.push_back(dir_row(CMD_READ,    0,   32'h0,        1, '1,    STS_INVALID, 0));
      dir_rows.push_back(dir_row(CMD_READ,    255, 32'h0,        1, '1,    STS_INVALID, 0));
      dir_rows.push_back(dir_row(CMD_DEL_AT,  0,   32'h0,        1, 32'h0, STS_INVALID, 0));
      dir_rows.push_back(dir_row(CMD_INSERT,  1,   32'h5,        1, 32'h0, STS_INVALID, 0));
      dir_rows.push_back(dir_row(CMD_INSERT,  255, 32'hFFFFFFFF, 1, 32'h0, STS_INVALID, 0));
      dir_rows.push_back(dir_row(CMD_SPARE,   255, 32'hFFFFFFFF, 1, 32'h0, STS_OK,      0));
      dir_rows.push_back(dir_row(CMD_APPEND,  0,   32'h7FFFFFFF, 1, 32'h0, STS_OK,      1));
      dir_rows.push_back(dir_row(CMD_READ,    0,   32'h0,    1, 32'h7FFFFFFF, STS_OK,   1));
      dir_rows.push_back(dir_row(CMD_DEL_TL,  0,   32'h0,        1, 32'h0, STS_OK,      0));
      dir_rows.push_back(dir_row(CMD_PREPEND, 0,   32'h80000000, 1, 32'h0, STS_OK,      1));
      dir_rows.push_back(dir_row(CMD_APPEND,  0,   32'hFFFFFFFF, 0, 32'h0, STS_OK,      0));
      dir_rows.push_back(dir_row(CMD_INSERT,  1,   32'h00000000, 0, 32'h0, STS_OK,      0));
      dir_rows.push_back(dir_row(CMD_INSERT,  3,   32'h12345678, 0, 32'h0, STS_OK,      0));
      dir_rows.push_back(dir_row(CMD_INSERT,  0,   32'hA5A5A5A5, 0, 32'h0, STS_OK,      0));
      dir_rows.push_back(dir_row(CMD_READ,    2,   32'h0,        0, 32'h0, STS_OK,      0));
      dir_rows.push_back(dir_row(CMD_READ,    4,   32'h0,        0, 32'h0, STS_OK,      0));
      dir_rows.push_back(dir_row(CMD_READ,    5,   32'h0,        1, '1,    STS_INVALID, 5));
      dir_rows.push_back(dir_row(CMD_DEL_AT,  2,   32'h0,        0, 32'h0, STS_OK,      0));
      dir_rows.push_back(dir_row(CMD_DEL_AT,  4,   32'h0,        1, 32'h0, STS_INVALID, 4));
      dir_rows.push_back(dir_row(CMD_DEL_HD,  0,   32'h0,        0, 32'h0, STS_OK,      0));
      dir_rows.push_back(dir_row(CMD_SPARE,   0,   32'h0,        0, 32'h0, STS_OK,      0));
      dir_rows.push_back(dir_row(CMD_DEL_AT,  0,   32'h0,        0, 32'h0, STS_OK,      0));
      dir_rows.push_back(dir_row(CMD_READ,    1,   32'h0,        0, 32'h0, STS_OK,      0));
      foreach (dir_rows[i]) send_list_cmd(dir_rows[i].req, dir_rows[i].fixed, dir_rows[i].rsp);
      wait_drained();

      // Random: four handshake patterns, each cycling grow / mixed / shrink streams
      for (p = 0; p < 4; p++) begin
         case (p)
            0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1:       begin send_idle_pct = 83; recv_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  recv_stall_pct = 83; end
            default: begin send_idle_pct = 22; recv_stall_pct = 22; end
         endcase
         for (e = 0; e < 6; e++) begin
            // long hold-off on the response side while requests keep coming
            if (p == 0 && e == 1) hold_request = 80;
            n = 0;
            while (n < EPISODE_LEN) begin
               c = make_list_cmd(e % 3);
               send_list_cmd(c, 0, no_rsp);
               if (c.cmd != CMD_SPARE) n++;
            end
         end
         // requests pause until every response is back
         wait_drained();
      end

      repeat (10) @(posedge clock);
      if (pending_rsp_q.size() != 0) begin
         $display("%0t: %0d responses never arrived", $time, pending_rsp_q.size());
         err_count++;
      end
      $display("Sent %0d commands under four handshake patterns with a long back-pressure hold.",
               cmds_sent);
      $display("Responses seen: ok %0d, bad index %0d, empty %0d, full %0d; mismatches %0d",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3], err_count);
      if (err_count == 0) begin
         $display("PASS indexed_sequence_store_core");
      end else begin
         $display("FAIL indexed_sequence_store_core");
      end
      $finish;
   end

endmodule

// File: files.f
+incdir+hdl
hdl/iss_pkg.sv
hdl/iss_ctrl.sv
hdl/iss_datapath.sv
hdl/indexed_sequence_store_core.sv
sim/tb_indexed_sequence_store_core.sv
